/* hdl/prqs_pkg.sv */
// Shared types and constants for the priority ready-queue scheduler.
// No dependencies; imported by priority_ready_queue_scheduler.
package prqs_pkg;

    localparam int OP_W     = 2;
    localparam int ID_W     = 4;
    localparam int PRI_IN_W = 8;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ID_W-1:0] pid_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_POP    = 2'd1;
    localparam op_t OP_SCHED  = 2'd2;

endpackage

/* hdl/priority_ready_queue_scheduler.sv */
// Priority ready queue with a running process, one shared compare unit and a sequencer.
// Depends on prqs_pkg (operation codes, field widths).
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------------------
//  input   | in_valid  | in_stall  | operation, proc_id, priority_req, still_ready
//  output  | out_valid | out_stall | chosen_id, got_one, rejected, queue_count
//
// A pop or a schedule without a requeue reads the head and then completes; an unused code or a
// refused insert goes straight to completion; an insert scans, and a schedule that requeues the
// running process reads the head and then scans; a scan shifts 0 to DEPTH-1 entries one slot toward
// the tail, one per cycle, in a circular buffer held in one memory with one read and one write port.
// Reset is asynchronous and empties the queue; process 0 runs at priority 0. A stalled result
// holds the output register while the next transaction runs; its result waits for it to leave.
module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter  int DEPTH     = 16,
    parameter  int PRI_WIDTH = 8,
    localparam int CNT_W     = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     operation,
    input  logic [ID_W-1:0]     proc_id,
    input  logic [PRI_IN_W-1:0] priority_req,
    input  logic                still_ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     chosen_id,
    output logic                got_one,
    output logic                rejected,
    output logic [CNT_W-1:0]    queue_count
);

    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HEAD = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    typedef logic [PRI_WIDTH-1:0] pri_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Queue storage, undefined until written.
    pid_t mem_id  [DEPTH];
    pri_t mem_pri [DEPTH];
    pid_t rd_id_reg;
    pri_t rd_pri_reg;

    logic       wr_en;
    idx_t       wr_addr;
    idx_t       rd_addr;
    pid_t       wr_id;
    pri_t       wr_pri;

    logic [1:0] state_reg, state_next;
    idx_t       head_reg, head_next;
    cnt_t       count_reg, count_next;
    pid_t       run_id_reg, run_id_next;
    pri_t       run_pri_reg, run_pri_next;
    logic       out_valid_reg, out_valid_next;

    op_t        op_reg, op_next;
    logic       ready_reg, ready_next;
    pid_t       ins_id_reg, ins_id_next;
    pri_t       ins_pri_reg, ins_pri_next;
    idx_t       pos_reg, pos_next;
    cnt_t       left_reg, left_next;
    pid_t       res_id_reg, res_id_next;
    logic       res_got_reg, res_got_next;
    logic       res_rej_reg, res_rej_next;
    pid_t       out_id_reg, out_id_next;
    logic       out_got_reg, out_got_next;
    logic       out_rej_reg, out_rej_next;
    cnt_t       out_cnt_reg, out_cnt_next;

    logic [CNT_W:0] tail_sum;
    idx_t           tail_idx;
    idx_t           tail_dec;
    idx_t           head_inc;
    idx_t           pos_dec;
    idx_t           pos_dec2;
    pri_t           cmp_b;
    logic           cmp_ge;
    logic           out_free;

    // Circular index arithmetic.
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail_idx = (tail_sum >= (CNT_W+1)'(DEPTH)) ?
                      IDX_W'(tail_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(tail_sum);
    assign tail_dec = (tail_idx == '0) ? IDX_W'(DEPTH - 1) : tail_idx - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign pos_dec  = (pos_reg == '0) ? IDX_W'(DEPTH - 1) : pos_reg - 1'b1;
    assign pos_dec2 = (pos_dec == '0) ? IDX_W'(DEPTH - 1) : pos_dec - 1'b1;

    // The one shared comparator: the entry just read against the running or inserted priority.
    assign cmp_ge = (rd_pri_reg >= cmp_b);

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        run_id_next    = run_id_reg;
        run_pri_next   = run_pri_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        ready_next     = ready_reg;
        ins_id_next    = ins_id_reg;
        ins_pri_next   = ins_pri_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        res_id_next    = res_id_reg;
        res_got_next   = res_got_reg;
        res_rej_next   = res_rej_reg;
        out_id_next    = out_id_reg;
        out_got_next   = out_got_reg;
        out_rej_next   = out_rej_reg;
        out_cnt_next   = out_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_id          = ins_id_reg;
        wr_pri         = ins_pri_reg;
        rd_addr        = head_reg;
        cmp_b          = ins_pri_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (operation == OP_INSERT) ? tail_dec : head_reg;
                if (in_valid)
                begin
                    op_next      = operation;
                    ready_next   = still_ready;
                    res_id_next  = '0;
                    res_got_next = 1'b0;
                    res_rej_next = 1'b0;
                    priority if (operation == OP_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_rej_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            ins_id_next  = proc_id;
                            ins_pri_next = PRI_WIDTH'(priority_req);
                            pos_next     = tail_idx;
                            left_next    = count_reg;
                            state_next   = ST_SCAN;
                        end
                    end
                    else if (operation == OP_POP || operation == OP_SCHED)
                    begin
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_HEAD:
            begin
                // The head entry is in the read register now.
                rd_addr    = tail_dec;
                cmp_b      = run_pri_reg;
                state_next = ST_DONE;
                priority if (op_reg == OP_POP)
                begin
                    if (count_reg != '0)
                    begin
                        head_next    = head_inc;
                        count_next   = count_reg - 1'b1;
                        res_id_next  = rd_id_reg;
                        res_got_next = 1'b1;
                    end
                end
                else if (ready_reg && (count_reg == '0 || !cmp_ge))
                begin
                    // The running process outranks the head, or the queue is empty, and keeps running.
                    res_id_next  = run_id_reg;
                    res_got_next = 1'b1;
                end
                else if (count_reg != '0)
                begin
                    head_next    = head_inc;
                    count_next   = count_reg - 1'b1;
                    run_id_next  = rd_id_reg;
                    run_pri_next = rd_pri_reg;
                    res_id_next  = rd_id_reg;
                    res_got_next = 1'b1;
                    if (ready_reg)
                    begin
                        // Requeue the old running process; the popped slot frees the tail.
                        ins_id_next  = run_id_reg;
                        ins_pri_next = run_pri_reg;
                        pos_next     = tail_idx;
                        left_next    = count_reg - 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Walk from the tail toward the head, moving lower-priority entries back.
                rd_addr = pos_dec2;
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                priority if (left_reg == '0 || cmp_ge)
                begin
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    wr_id     = rd_id_reg;
                    wr_pri    = rd_pri_reg;
                    pos_next  = pos_dec;
                    left_next = left_reg - 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_id_reg;
                    out_got_next   = res_got_reg;
                    out_rej_next   = res_rej_reg;
                    out_cnt_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[wr_addr]  <= wr_id;
            mem_pri[wr_addr] <= wr_pri;
        end
        rd_id_reg  <= mem_id[rd_addr];
        rd_pri_reg <= mem_pri[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            run_id_reg    <= '0;
            run_pri_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            run_id_reg    <= run_id_next;
            run_pri_reg   <= run_pri_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ready_reg   <= ready_next;
        ins_id_reg  <= ins_id_next;
        ins_pri_reg <= ins_pri_next;
        pos_reg     <= pos_next;
        left_reg    <= left_next;
        res_id_reg  <= res_id_next;
        res_got_reg <= res_got_next;
        res_rej_reg <= res_rej_next;
        out_id_reg  <= out_id_next;
        out_got_reg <= out_got_next;
        out_rej_reg <= out_rej_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_valid   = out_valid_reg;
    assign chosen_id   = out_id_reg;
    assign got_one     = out_got_reg;
    assign rejected    = out_rej_reg;
    assign queue_count = out_cnt_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_scan_within_queue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> left_reg <= count_reg)
        else $error("insert scan runs past the queued entries");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result loaded outside the completion step");

    a_reject_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rej_reg |-> out_cnt_reg == CNT_W'(DEPTH) && !out_got_reg)
        else $error("refused insert reported with a queue that was not full");

    a_scan_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && state_next == ST_SCAN |=> left_reg == $past(left_reg) - 1'b1)
        else $error("insert scan did not advance by one entry");

endmodule
